@@ src/maes_pkg.sv @@
package maes_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Running sum carries this many bits above the sample width
  localparam int SUM_GUARD = 7;

  // Register widths and reset values
  localparam int WIN_BITS      = 7;
  localparam int GAIN_BITS     = 17;
  localparam int GAIN_FRAC     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 17'h10000;
  localparam logic [GAIN_BITS-1:0] GAIN_RST  = 17'h08000;
  localparam logic [WIN_BITS-1:0]  WIN_RST   = 7'd8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ACCUM,
    ST_DIV,
    ST_FINISH
  } maes_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // take the input sample, last flag and window length
    logic load;      // read old sample, start both products
    logic accum;     // update sums, delay line, smoother; seed divider
    logic div_step;  // one quotient bit
    logic finish;    // form the result, push it out, clear on end of record
  } maes_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } maes_stat_t;

endpackage

@@ src/maes_ram.sv @@
module maes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/maes_ctrl.sv @@
module maes_ctrl import maes_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  maes_stat_t stat,
  output maes_cmd_t  cmd
);

  localparam int SUM_W = SAMPLE_BITS + SUM_GUARD;
  localparam int CNT_W = $clog2(SUM_W);

  maes_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        cnt_nxt   = CNT_W'(SUM_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ src/maes_dp.sv @@
module maes_dp import maes_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  maes_cmd_t                     cmd,
  output maes_stat_t                    stat,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [GAIN_BITS-1:0]          cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_data,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [SAMPLE_BITS-1:0]        out_data
);

  localparam int NW     = $clog2(MAX_WINDOW + 1);
  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int DIFF_W = NW + 1;
  localparam int SUM_W  = SAMPLE_BITS + SUM_GUARD;
  localparam int ACC_W  = SAMPLE_BITS + GAIN_BITS;
  localparam int P1_W   = ACC_W + GAIN_BITS + 1;
  localparam int P2_W   = SAMPLE_BITS + GAIN_BITS + 1;
  localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration
  logic                 mode_r;
  logic [WIN_BITS-1:0]  win_r;
  logic [GAIN_BITS-1:0] gain_r;

  // record state
  logic [NW-1:0]           seen_r;
  logic [AW-1:0]           wp_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [ACC_W-1:0] acc_r;

  // per-item working registers
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          last_r;
  logic [NW-1:0]                 n_r;
  logic signed [P1_W-1:0]        p1_r;
  logic signed [P2_W-1:0]        p2_r;
  logic                          neg_r;
  logic [SUM_W-1:0]              quo_r;
  logic [NW-1:0]                 rem_r;
  logic [NW-1:0]                 div_r;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_data_r;

  logic [NW-1:0]                 n_clamp;
  logic                          warm;
  logic [DIFF_W-1:0]             pos_diff;
  logic [AW-1:0]                 old_pos;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic signed [SAMPLE_BITS-1:0] old_s;
  logic signed [SUM_W-1:0]       sum_nxt;
  logic [SUM_W-1:0]              sum_abs;
  logic [GAIN_BITS-1:0]          alpha_sat;
  logic signed [GAIN_BITS:0]     alpha_s;
  logic signed [GAIN_BITS:0]     comp_s;
  logic signed [P1_W-1:0]        p1_w;
  logic signed [P2_W-1:0]        p2_w;
  logic signed [P1_W-1:0]        p1_adj;
  logic signed [P1_W-1:0]        p1_sh;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic [NW:0]                   rem_sh;
  logic                          rem_ge;
  logic signed [SUM_W:0]         q_s;
  logic [SAMPLE_BITS-1:0]        avg_sat;
  logic signed [ACC_W-1:0]       acc_adj;
  logic signed [SAMPLE_BITS:0]   expo_w;
  logic [SAMPLE_BITS-1:0]        expo_sat;

  // window length limited to 1..MAX_WINDOW
  always_comb begin
    if (int'(win_r) > MAX_WINDOW) begin
      n_clamp = NW'(MAX_WINDOW);
    end else if (win_r == '0) begin
      n_clamp = NW'(1);
    end else begin
      n_clamp = NW'(win_r);
    end
  end

  assign warm     = seen_r < n_r;
  assign pos_diff = DIFF_W'(wp_r) - DIFF_W'(n_r);
  assign old_pos  = pos_diff[DIFF_W-1] ? AW'(pos_diff + DIFF_W'(MAX_WINDOW))
                                       : AW'(pos_diff);

  maes_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_delay (
    .clk   (clk),
    .we    (cmd.accum),
    .waddr (wp_r),
    .wdata (x_r),
    .raddr (old_pos),
    .rdata (rd_data)
  );

  assign old_s   = rd_data;
  assign sum_nxt = warm ? sum_r + SUM_W'(x_r)
                        : sum_r - SUM_W'(old_s) + SUM_W'(x_r);
  assign sum_abs = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);

  // exponential smoother: acc = trunc((1 - a) * acc) + a * x
  assign alpha_sat = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;
  assign alpha_s   = signed'({1'b0, alpha_sat});
  assign comp_s    = signed'({1'b0, GAIN_ONE - alpha_sat});
  assign p1_w      = comp_s * acc_r;
  assign p2_w      = alpha_s * x_r;
  assign p1_adj    = p1_r + signed'({{(P1_W-GAIN_FRAC){1'b0}}, {GAIN_FRAC{p1_r[P1_W-1]}}});
  assign p1_sh     = p1_adj >>> GAIN_FRAC;
  assign acc_nxt   = p1_sh[ACC_W-1:0] + p2_r[ACC_W-1:0];

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_r};

  assign q_s = neg_r ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
  always_comb begin
    if ((&q_s[SUM_W:SAMPLE_BITS-1]) || !(|q_s[SUM_W:SAMPLE_BITS-1])) begin
      avg_sat = q_s[SAMPLE_BITS-1:0];
    end else begin
      avg_sat = q_s[SUM_W] ? SAT_LO : SAT_HI;
    end
  end

  assign acc_adj = acc_r + signed'({{(ACC_W-GAIN_FRAC){1'b0}}, {GAIN_FRAC{acc_r[ACC_W-1]}}});
  assign expo_w  = acc_adj[ACC_W-1:GAIN_FRAC];
  always_comb begin
    if (expo_w[SAMPLE_BITS] == expo_w[SAMPLE_BITS-1]) begin
      expo_sat = expo_w[SAMPLE_BITS-1:0];
    end else begin
      expo_sat = expo_w[SAMPLE_BITS] ? SAT_LO : SAT_HI;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      win_r       <= WIN_RST;
      gain_r      <= GAIN_RST;
      seen_r      <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:   mode_r <= cfg_data[0];
          CFG_WINDOW: win_r  <= cfg_data[WIN_BITS-1:0];
          CFG_GAIN:   gain_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accum) begin
        sum_r  <= sum_nxt;
        acc_r  <= acc_nxt;
        wp_r   <= (int'(wp_r) == MAX_WINDOW - 1) ? '0 : wp_r + 1'b1;
        if (seen_r != NW'(MAX_WINDOW)) begin
          seen_r <= seen_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        // drop record state after the last sample's result
        if (last_r) begin
          sum_r  <= '0;
          acc_r  <= '0;
          wp_r   <= '0;
          seen_r <= '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r    <= in_data;
      last_r <= in_last;
      n_r    <= n_clamp;
    end
    if (cmd.load) begin
      p1_r <= p1_w;
      p2_r <= p2_w;
    end
    if (cmd.accum) begin
      neg_r <= sum_nxt[SUM_W-1];
      quo_r <= sum_abs;
      rem_r <= '0;
      div_r <= warm ? seen_r + 1'b1 : n_r;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? NW'(rem_sh - {1'b0, div_r}) : NW'(rem_sh);
      quo_r <= {quo_r[SUM_W-2:0], rem_ge};
    end
    if (cmd.finish) begin
      out_data_r <= mode_r ? expo_sat : avg_sat;
    end
  end

endmodule

@@ src/moving_average_or_exponential_smoother.sv @@
// Channel  Direction  Handshake                Payload
// in_      sink       in_tvalid / in_tready    in_tdata: sample_value; in_tlast: last_in_record
// out_     source     out_tvalid / out_tready  out_tdata: smoothed_value
// cfg_     sink       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One sample at a time: no new sample is taken until the current one has passed the
// one-bit-per-cycle restoring divider of the average and its result has entered the
// output register.
// The output register lets the next sample enter while a result waits.
// Synchronous active-low reset sets configuration to its reset values and clears record state; the delay
// line RAM is not cleared and is only read at slots written in the current record.
// A stalled out_tready holds the finished item before it enters the output register.
module moving_average_or_exponential_smoother import maes_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // [SAMPLE_BITS-1:0] sample_value
  input  logic                                in_tlast,   // last_in_record
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,  // [SAMPLE_BITS-1:0] smoothed_value
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]             cfg_index,
  input  logic [GAIN_BITS-1:0]                cfg_data
);

  localparam int BUS_W = ((SAMPLE_BITS + 7) / 8) * 8;

  maes_cmd_t              cmd;
  maes_stat_t             stat;
  logic [SAMPLE_BITS-1:0] result;

  assign cfg_ready = 1'b1;
  assign out_tdata = BUS_W'(result);

  maes_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  maes_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_tdata[SAMPLE_BITS-1:0]),
    .in_last   (in_tlast),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (result)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.load, cmd.accum, cmd.div_step, cmd.finish}))
    else $error("more than one datapath command at once");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> stat.out_free)
    else $error("result pushed into a full output register");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_tvalid)
    else $error("finished result not presented");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second sample taken while one is in work");

endmodule

@@ tb/tb_moving_average_or_exponential_smoother.sv @@
module tb_moving_average_or_exponential_smoother import maes_pkg::*;;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int DATA_W      = ((SB + 7) / 8) * 8;
  localparam int SUM_W       = SB + SUM_GUARD;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 60;
  localparam int REPORT_MAX  = 10;

  localparam longint GAIN_UNITY = longint'(1) << GAIN_FRAC;
  localparam longint SAMPLE_HI  = (longint'(1) << (SB - 1)) - 1;
  localparam longint SAMPLE_LO  = -SAMPLE_HI - 1;

  localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] SAMPLE_NEG1 = {SB{1'b1}};

  // index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_t;

  class smoothing_scoreboard;
    logic                      mode_sel;
    logic [WIN_BITS-1:0]       window_reg;
    logic [GAIN_BITS-1:0]      gain_reg;
    logic signed [SB-1:0]      history [MAX_WINDOW_DEF];
    logic signed [SUM_W-1:0]   window_sum;
    int                        fill_count;
    int                        write_slot;
    longint                    exp_acc;
    logic [SB-1:0]             smoothed_due [$];
    int                        mismatches;

    function new();
      mode_sel   = 1'b0;
      window_reg = WIN_RST;
      gain_reg   = GAIN_RST;
      mismatches = 0;
      foreach (history[i]) history[i] = '0;
      restart_record();
    endfunction

    function void restart_record();
      window_sum = '0;
      fill_count = 0;
      write_slot = 0;
      exp_acc    = 0;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] data);
      case (idx)
        CFG_MODE:   mode_sel = data[0];
        CFG_WINDOW: window_reg = data[WIN_BITS-1:0];
        CFG_GAIN:   gain_reg = data;
        default: ;
      endcase
    endfunction

    function void predict_smoothed(logic [SB-1:0] raw, logic is_last);
      logic signed [SB-1:0] x;
      int     span;
      int     oldest;
      longint total;
      longint average;
      longint expo;
      longint alpha;
      longint y;
      x = raw;
      span = int'(window_reg);
      if (span == 0) span = 1;
      if (span > MAX_WINDOW_DEF) span = MAX_WINDOW_DEF;
      // warm-up divides by the count so far, then slide the window
      if (fill_count < span) begin
        total = longint'(window_sum) + longint'(x);
        window_sum = total[SUM_W-1:0];
        average = longint'(window_sum) / longint'(fill_count + 1);
      end else begin
        oldest = (write_slot + MAX_WINDOW_DEF - span) % MAX_WINDOW_DEF;
        total = longint'(window_sum) - longint'(history[oldest]) + longint'(x);
        window_sum = total[SUM_W-1:0];
        average = longint'(window_sum) / longint'(span);
      end
      history[write_slot] = x;
      write_slot = (write_slot + 1) % MAX_WINDOW_DEF;
      if (fill_count < MAX_WINDOW_DEF) fill_count++;

      alpha = longint'(gain_reg);
      if (alpha > GAIN_UNITY) alpha = GAIN_UNITY;
      exp_acc = ((GAIN_UNITY - alpha) * exp_acc) / GAIN_UNITY + alpha * longint'(x);
      expo = exp_acc / GAIN_UNITY;

      y = mode_sel ? expo : average;
      if (y > SAMPLE_HI) y = SAMPLE_HI;
      if (y < SAMPLE_LO) y = SAMPLE_LO;
      smoothed_due.push_back(y[SB-1:0]);
      if (is_last) restart_record();
    endfunction

    function void check_smoothed(logic [SB-1:0] got);
      logic [SB-1:0] want;
      if (smoothed_due.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("result %0d arrived with no sample pending", $signed(got));
        mismatches++;
      end else begin
        want = smoothed_due.pop_front();
        if (got !== want) begin
          if (mismatches < REPORT_MAX)
            $display("smoothed_value mismatch: expected %0d, got %0d",
                     $signed(want), $signed(got));
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [DATA_W-1:0]       in_tdata = '0;
  logic                    in_tlast = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [DATA_W-1:0]       out_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [GAIN_BITS-1:0]    cfg_data = '0;

  smoothing_scoreboard sb = new();
  int          items_sent = 0;
  int          record_left = 0;
  int          cycle_count = 0;
  rx_pattern_t rx_pattern = RX_OPEN;
  int          rx_cycle = 0;
  int          rx_hold = 0;

  moving_average_or_exponential_smoother uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.predict_smoothed(in_tdata[SB-1:0], in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_smoothed(out_tdata[SB-1:0]);
  end

  // receiver: open, random, sparse or bursty stall pattern, switched at random over the run
  always @(posedge clk) begin
    if (rx_cycle % 300 == 0) rx_pattern = rx_pattern_t'($urandom_range(0, 3));
    case (rx_pattern)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (rx_cycle % 8 == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(5, 40);
        end
      end
    endcase
    rx_cycle++;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("moving_average_or_exponential_smoother regression: fail");
    $finish;
  end

  // leaves valid high; the caller lowers it
  task automatic push_sample(logic [SB-1:0] v, logic is_last);
    in_tdata  <= DATA_W'(v);
    in_tlast  <= is_last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    items_sent++;
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= DATA_W'($urandom);
      in_tlast  <= 1'($urandom_range(0, 1));
      repeat (n) @(posedge clk);
    end
  endtask

  // step past the last transfer edge so the monitor has queued it, then wait it out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.smoothed_due.size() != 0) @(posedge clk);
  endtask

  // leaves valid high; the caller lowers it
  task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_register(idx, data);
  endtask

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3, 4:    return SB'($urandom_range(0, 31) - 16);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic int pick_record_length();
    case ($urandom_range(0, 9))
      0:          return 1;
      1:          return $urandom_range(2, 4);
      2, 3, 4, 5: return $urandom_range(5, 70);
      6, 7, 8:    return $urandom_range(60, 200);
      default:    return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return $urandom_range(4, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic random_config();
    logic [GAIN_BITS-1:0] data;
    bit                   wrote;
    wrote = 1'b0;
    if ($urandom_range(0, 3) != 0) begin
      write_cfg(CFG_MODE, GAIN_BITS'($urandom));
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      data = GAIN_BITS'($urandom);
      case ($urandom_range(0, 9))
        0:       data[WIN_BITS-1:0] = 7'd1;
        1:       data[WIN_BITS-1:0] = 7'd64;
        2:       data[WIN_BITS-1:0] = 7'd0;
        3:       data[WIN_BITS-1:0] = WIN_BITS'($urandom_range(65, 127));
        default: data[WIN_BITS-1:0] = WIN_BITS'($urandom_range(1, 64));
      endcase
      write_cfg(CFG_WINDOW, data);
      wrote = 1'b1;
    end
    if (!wrote || $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:       data = '0;
        1:       data = GAIN_ONE;
        2:       data = GAIN_BITS'($urandom_range(65537, 131071));
        3:       data = GAIN_BITS'($urandom_range(0, 511));
        4:       data = GAIN_BITS'($urandom_range(65000, 65536));
        default: data = GAIN_BITS'($urandom_range(0, 65536));
      endcase
      write_cfg(CFG_GAIN, data);
    end
    if ($urandom_range(0, 7) == 0) write_cfg(CFG_SPARE, GAIN_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_phase(int count);
    int   k;
    int   burst_left;
    bit   calm;
    logic is_last;
    calm = ($urandom_range(0, 3) == 0);
    burst_left = $urandom_range(1, 24);
    for (k = 0; k < count; k++) begin
      if (record_left == 0) record_left = pick_record_length();
      is_last = (record_left == 1);
      record_left--;
      push_sample(pick_sample(), is_last);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (!calm) pause(pick_gap());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: average over eight, both extremes, end of record
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample('0, 1'b0);
    push_sample(SAMPLE_NEG1, 1'b0);
    push_sample(SB'(1), 1'b0);
    push_sample(SB'(16'h1234), 1'b1);
    drain();

    // exponential with zero gain; upper data bits set on the mode write
    write_cfg(CFG_MODE, {GAIN_BITS{1'b1}});
    write_cfg(CFG_GAIN, '0);
    cfg_valid <= 1'b0;
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MAX, 1'b1);
    drain();

    write_cfg(CFG_GAIN, GAIN_ONE);
    cfg_valid <= 1'b0;
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    drain();

    // gain above unity saturates, mid-record
    write_cfg(CFG_GAIN, {GAIN_BITS{1'b1}});
    cfg_valid <= 1'b0;
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MAX, 1'b1);
    drain();

    // window zero acts as one; spare index is ignored
    write_cfg(CFG_MODE, {{(GAIN_BITS-1){1'b1}}, 1'b0});
    write_cfg(CFG_WINDOW, '0);
    write_cfg(CFG_SPARE, {GAIN_BITS{1'b1}});
    cfg_valid <= 1'b0;
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SB'(5), 1'b0);
    drain();

    // window above the maximum, changed mid-record
    write_cfg(CFG_WINDOW, GAIN_BITS'(7'h7F));
    cfg_valid <= 1'b0;
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MAX, 1'b1);
    drain();

    write_cfg(CFG_WINDOW, GAIN_BITS'(7'd64));
    cfg_valid <= 1'b0;
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      random_config();
      send_phase($urandom_range(20, 150));
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.smoothed_due.size() == 0) begin
      $display("moving_average_or_exponential_smoother regression: pass");
    end else begin
      $display("moving_average_or_exponential_smoother regression: fail");
    end
    $finish;
  end

endmodule
